FILE: rtl/core/shortest_queue_dispatcher_unit_defines.svh
// Assertion macros shared by the dispatcher RTL.
// SQD_ASSERT checks under the block's clock with reset masked.
// SQD_ASSERT_ALWAYS checks under the block's clock at every edge.
`ifndef SHORTEST_QUEUE_DISPATCHER_UNIT_DEFINES_SVH
`define SHORTEST_QUEUE_DISPATCHER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SQD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SQD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SQD_ASSERT(lbl, prop, msg)
`define SQD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/sqd_pkg.sv
`timescale 1ns / 1ps

package sqd_pkg;

	// Default sizing
	localparam int NUM_SERVERS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 16;

	// Most departures emitted for one tick
	localparam int MAX_RESULTS = 64;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	// Input operation codes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_DEPART = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_WRITE,
		ST_HEAD,
		ST_READ,
		ST_FLUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_ready;
		logic start_arr;
		logic start_tick;
		logic scan_step;
		logic scan_done;
		logic calc_start;
		logic arr_commit;
		logic arr_reject;
		logic head_rd;
		logic depart;
		logic next_srv;
		logic flush;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_tick;
		logic scan_more;
		logic full;
		logic out_free;
		logic head_ok;
		logic due;
		logic pend_v;
		logic last_srv;
	} sts_t;

endpackage

FILE: rtl/core/sqd_if.sv
`timescale 1ns / 1ps

// Job and tick channel
interface sqd_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] job_id;
	logic [15:0] service_time;

	modport source (output valid, operation, job_id, service_time, input ready);
	modport sink   (input valid, operation, job_id, service_time, output ready);
endinterface

// Result channel
interface sqd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] out_job_id;
	logic [31:0] finish_time;
	logic [1:0]  server_index;
	logic        last;

	modport source (output valid, kind, out_job_id, finish_time, server_index, last,
		input ready);
	modport sink   (input valid, kind, out_job_id, finish_time, server_index, last,
		output ready);
endinterface

// Register write channel
interface sqd_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] active_servers;

	modport source (output valid, active_servers, input ready);
	modport sink   (input valid, active_servers, output ready);
endinterface

FILE: rtl/core/sqd_ctrl.sv
`timescale 1ns / 1ps
`include "shortest_queue_dispatcher_unit_defines.svh"

module sqd_ctrl
	import sqd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nx;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) begin
					state_nx = sts.in_tick ? ST_HEAD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!sts.scan_more) begin
					state_nx = ST_CALC;
				end
			end
			ST_CALC: begin
				state_nx = ST_WRITE;
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_HEAD: begin
				if (sts.head_ok) begin
					state_nx = ST_READ;
				end else if (sts.last_srv) begin
					state_nx = ST_FLUSH;
				end
			end
			ST_READ: begin
				if (sts.due) begin
					if (!sts.pend_v || sts.out_free) begin
						state_nx = ST_HEAD;
					end
				end else begin
					state_nx = sts.last_srv ? ST_FLUSH : ST_HEAD;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_v || sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready   = 1'b1;
				cmd.start_arr  = sts.in_valid && !sts.in_tick;
				cmd.start_tick = sts.in_valid && sts.in_tick;
			end
			ST_SCAN: begin
				cmd.scan_step = sts.scan_more;
				cmd.scan_done = !sts.scan_more;
			end
			ST_CALC: begin
				cmd.calc_start = 1'b1;
			end
			ST_WRITE: begin
				cmd.arr_commit = sts.out_free && !sts.full;
				cmd.arr_reject = sts.out_free && sts.full;
			end
			ST_HEAD: begin
				cmd.head_rd  = sts.head_ok;
				cmd.next_srv = !sts.head_ok && !sts.last_srv;
			end
			ST_READ: begin
				cmd.depart   = sts.due && (!sts.pend_v || sts.out_free);
				cmd.next_srv = !sts.due && !sts.last_srv;
			end
			ST_FLUSH: begin
				cmd.flush = sts.pend_v && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// A departure only follows a read of a due head
	`SQD_ASSERT(a_depart_due, cmd.depart |-> (state_q == ST_READ) && sts.due, "depart not due")
	// The last beat of a tick carries a real job
	`SQD_ASSERT(a_flush_pend, cmd.flush |-> sts.pend_v, "flush without pending job")
	// Scan always ends in the placement steps
	`SQD_ASSERT(a_scan_calc, (state_q == ST_SCAN) && !sts.scan_more |=> state_q == ST_CALC,
		"scan did not advance")

endmodule

FILE: rtl/core/sqd_datapath.sv
`timescale 1ns / 1ps
`include "shortest_queue_dispatcher_unit_defines.svh"

module sqd_datapath
	import sqd_pkg::*;
#(
	parameter int NUM_SERVERS = NUM_SERVERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sqd_in_if.sink     req,
	sqd_out_if.source  rsp,
	sqd_cfg_if.sink    cfg,
	input  cmd_t       cmd,
	output sts_t       sts
);

	localparam int SW    = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int TW    = CW + 1;
	localparam int DEPTH = NUM_SERVERS * (2 ** HW);

	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [HW-1:0] HEAD_TOP = HW'(QUEUE_DEPTH - 1);
	localparam logic [TW-1:0] TAIL_LIM = TW'(QUEUE_DEPTH);
	localparam logic [SW:0]   SRV_TOP  = (SW + 1)'(NUM_SERVERS - 1);
	localparam logic [SW:0]   SRV_ALL  = (SW + 1)'(NUM_SERVERS);

	// Per-server queue state
	logic [31:0]   now_q;
	logic [2:0]    active_q;
	logic [CW-1:0] count_q [NUM_SERVERS];
	logic [HW-1:0] head_q  [NUM_SERVERS];
	logic [31:0]   tailf_q [NUM_SERVERS];

	// Job store: id over finish time
	logic [47:0]   mem [DEPTH];
	logic [47:0]   rd_q;

	// Item and scan registers
	logic [15:0]          id_q;
	logic [15:0]          svc_q;
	logic [SW:0]          srv_q;
	logic [SW-1:0]        best_q;
	logic [CW-1:0]        best_cnt_q;
	logic [31:0]          start_q;
	logic [RES_CNT_W-1:0] n_q;

	// Held departure, waiting to learn whether it is the last one
	logic        pend_v_q;
	logic [15:0] pend_id_q;
	logic [31:0] pend_fin_q;
	logic [1:0]  pend_srv_q;

	// Output register
	logic        out_v_q;
	logic [1:0]  out_kind_q;
	logic [15:0] out_id_q;
	logic [31:0] out_fin_q;
	logic [1:0]  out_srv_q;
	logic        out_last_q;

	logic [SW-1:0] srv_idx;
	logic [SW:0]   act_eff;
	logic [CW-1:0] cnt_sel;
	logic [HW-1:0] head_sel;
	logic [TW-1:0] tail_sum;
	logic [HW-1:0] tail;
	logic [HW-1:0] head_nx;
	logic [32:0]   fin_sum;
	logic [31:0]   fin;
	logic [31:0]   start_nx;
	logic          load;
	logic          out_free;

	assign srv_idx  = srv_q[SW-1:0];
	assign cnt_sel  = count_q[srv_idx];
	assign head_sel = head_q[srv_idx];

	// Clamp the active server count to one through NUM_SERVERS
	always_comb begin
		if (active_q == 3'd0) begin
			act_eff = (SW + 1)'(1);
		end else if (32'(active_q) > 32'(NUM_SERVERS)) begin
			act_eff = SRV_ALL;
		end else begin
			act_eff = (SW + 1)'(active_q);
		end
	end

	// Queue positions
	always_comb begin
		tail_sum = TW'(head_sel) + TW'(cnt_sel);
		if (tail_sum >= TAIL_LIM) begin
			tail_sum = tail_sum - TAIL_LIM;
		end
		tail    = tail_sum[HW-1:0];
		head_nx = (head_sel == HEAD_TOP) ? '0 : head_sel + HW'(1);
	end

	// Finish time, saturating
	always_comb begin
		start_nx = (tailf_q[srv_idx] > now_q) ? tailf_q[srv_idx] : now_q;
		fin_sum  = {1'b0, start_q} + {17'd0, svc_q};
		fin      = fin_sum[32] ? TIME_MAX : fin_sum[31:0];
	end

	assign out_free = !out_v_q || rsp.ready;
	assign load     = cmd.arr_commit || cmd.arr_reject || cmd.flush
		|| (cmd.depart && pend_v_q);

	// Status
	always_comb begin
		sts.in_valid  = req.valid;
		sts.in_tick   = (req.operation == OP_TICK);
		sts.scan_more = (srv_q < act_eff);
		sts.full      = (best_cnt_q == CNT_FULL);
		sts.out_free  = out_free;
		sts.head_ok   = (n_q < RES_CNT_W'(MAX_RESULTS)) && (cnt_sel != '0);
		sts.due       = (rd_q[31:0] <= now_q);
		sts.pend_v    = pend_v_q;
		sts.last_srv  = (srv_q == SRV_TOP);
	end

	assign req.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;

	// Register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			active_q <= 3'd4;
			srv_q    <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			for (int i = 0; i < NUM_SERVERS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				tailf_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				active_q <= cfg.active_servers;
			end
			if (cmd.start_arr) begin
				srv_q <= (SW + 1)'(1);
			end
			if (cmd.start_tick) begin
				if (now_q != TIME_MAX) begin
					now_q <= now_q + 32'd1;
				end
				srv_q    <= '0;
				n_q      <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.scan_step || cmd.next_srv) begin
				srv_q <= srv_q + (SW + 1)'(1);
			end
			if (cmd.scan_done) begin
				srv_q <= {1'b0, best_q};
			end
			if (cmd.arr_commit) begin
				count_q[srv_idx] <= cnt_sel + CW'(1);
				tailf_q[srv_idx] <= fin;
			end
			if (cmd.depart) begin
				head_q[srv_idx]  <= head_nx;
				count_q[srv_idx] <= cnt_sel - CW'(1);
				n_q              <= n_q + RES_CNT_W'(1);
				pend_v_q         <= 1'b1;
			end
			if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Item payload, scan winner and held departure
	always_ff @(posedge clk) begin
		if (cmd.start_arr) begin
			id_q       <= req.job_id;
			svc_q      <= req.service_time;
			best_q     <= '0;
			best_cnt_q <= count_q[0];
		end
		if (cmd.scan_step && (cnt_sel < best_cnt_q)) begin
			best_q     <= srv_idx;
			best_cnt_q <= cnt_sel;
		end
		if (cmd.calc_start) begin
			start_q <= start_nx;
		end
		if (cmd.depart) begin
			pend_id_q  <= rd_q[47:32];
			pend_fin_q <= rd_q[31:0];
			pend_srv_q <= 2'(srv_idx);
		end
	end

	// Job store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.arr_commit) begin
			mem[{srv_idx, tail}] <= {id_q, fin};
		end
		if (cmd.head_rd) begin
			rd_q <= mem[{srv_idx, head_sel}];
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.arr_commit) begin
			out_kind_q <= KIND_ACCEPT;
			out_id_q   <= id_q;
			out_fin_q  <= fin;
			out_srv_q  <= 2'(srv_idx);
			out_last_q <= 1'b1;
		end else if (cmd.arr_reject) begin
			out_kind_q <= KIND_REJECT;
			out_id_q   <= id_q;
			out_fin_q  <= '0;
			out_srv_q  <= '0;
			out_last_q <= 1'b1;
		end else if (load) begin
			out_kind_q <= KIND_DEPART;
			out_id_q   <= pend_id_q;
			out_fin_q  <= pend_fin_q;
			out_srv_q  <= pend_srv_q;
			out_last_q <= cmd.flush;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.out_job_id   = out_id_q;
	assign rsp.finish_time  = out_fin_q;
	assign rsp.server_index = out_srv_q;
	assign rsp.last         = out_last_q;

	// Never overwrite a result still waiting
	`SQD_ASSERT(a_no_overwrite, load |-> out_free, "result overwritten")
	// Placement only into a queue with room
	`SQD_ASSERT(a_room, cmd.arr_commit |-> best_cnt_q < CNT_FULL, "placed into full queue")
	// Time moves by at most one per cycle
	`SQD_ASSERT(a_time_step, 1'b1 |=> (now_q == $past(now_q)) || (now_q == $past(now_q) + 32'd1),
		"time jumped")
	// Departure count per tick stays bounded
	`SQD_ASSERT_ALWAYS(a_n_bound, n_q <= RES_CNT_W'(MAX_RESULTS), "too many departures")

endmodule

FILE: rtl/core/shortest_queue_dispatcher_unit.sv
`timescale 1ns / 1ps
// Channel   Modport  Beat
// cfg       sink     active_servers register write, always ready
// req       sink     operation, job_id, service_time
// rsp       source   kind, out_job_id, finish_time, server_index, last
//
// An arrival (active server count clamped to 1..NUM_SERVERS) steps through the accept, a scan
// of the active servers, the start time compare, then the saturating add and result write.
// A tick steps through the accept, then per server a registered read of the queue head and a
// due check; each due head departs, and a flush emits the held departure, if any, as the last.
// Reset (arst_n low) empties all queues, sets time to zero and active_servers to 4.
// A stalled rsp holds the result register; the next item is still taken when idle.

module shortest_queue_dispatcher_unit
	import sqd_pkg::*;
#(
	parameter int NUM_SERVERS = NUM_SERVERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sqd_cfg_if.sink   cfg,
	sqd_in_if.sink    req,
	sqd_out_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	// Sequence the item
	sqd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Queues, job store and result register
	sqd_datapath #(
		.NUM_SERVERS (NUM_SERVERS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
